// ----- sv/bdgp_pkg.sv -----
package bdgp_pkg;

    localparam int MAX_SRC_WIDTH   = 512;
    localparam int MAX_SRC_HEIGHT  = 512;
    localparam int MAX_OUT_DIM     = 4096;
    localparam int COORD_FRAC_BITS = 8;

    localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // field and register widths
    localparam int DEPTH_W = 32;
    localparam int PIX_W   = 12;
    localparam int SRC_W   = 10;
    localparam int OUT_W   = 13;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 9;                         // integer source coordinate
    localparam int CRD_W   = IDX_W + COORD_FRAC_BITS;   // clamped fixed-point coordinate
    localparam int WGT_W   = COORD_FRAC_BITS + 1;       // interpolation weight, 0..CF

    // datapath widths
    localparam int MA_W   = DEPTH_W + COORD_FRAC_BITS + 1;  // multiplier operand
    localparam int PROD_W = MA_W + WGT_W;
    localparam int V_W    = MA_W;                           // interpolated value
    localparam int D_W    = DEPTH_W + COORD_FRAC_BITS;      // bound range
    localparam int NUM_W  = D_W + 9;                        // 510*diff + d
    localparam int DEN_W  = D_W + 1;
    localparam int Q_W    = NUM_W;
    localparam int CNT_W  = 5;
    localparam int CPRD_W = PIX_W + 1 + SRC_W;
    localparam int CNUM_W = CPRD_W + COORD_FRAC_BITS;       // coordinate numerator
    localparam int N_BITS = 8;                              // normalize quotient bits

    typedef enum logic [2:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_OUT_WIDTH,
        CFG_OUT_HEIGHT,
        CFG_PCT_LOW,
        CFG_PCT_HIGH,
        CFG_MIN_VALUE,
        CFG_MAX_VALUE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DK_X,
        DK_Y,
        DK_N
    } t_div_kind;

    typedef enum logic [2:0] {
        MAC_E00,
        MAC_E10,
        MAC_E01,
        MAC_E11,
        MAC_B,
        MAC_AY,
        MAC_BY,
        MAC_V
    } t_mac_step;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XS,
        S_XW,
        S_YS,
        S_YW,
        S_FETCH,
        S_MAC,
        S_NORM,
        S_NS,
        S_NW,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic      load_go;
        logic      req_go;
        logic      div_go;
        t_div_kind div_kind;
        logic      cx_lat;
        logic      cy_lat;
        logic      v_zero;
        logic      rd_go;
        logic [1:0] rd_idx;   // bit 0 picks x1, bit 1 picks y1
        logic      cap_go;
        logic [1:0] cap_idx;
        logic      mac_go;
        t_mac_step mac_step;
        logic      norm_lat;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic zero_size;
        logic div_done;
        logic trivial;
        logic out_free;
    } t_stat;

endpackage

// ----- sv/bdgp_div.sv -----
module bdgp_div
    import bdgp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DEN_W-1:0] i_rem,
    input  logic [Q_W-1:0]   i_quo,
    input  logic [CNT_W-1:0] i_iters,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quo
);

    logic [DEN_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_quo[Q_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_quo <= i_quo;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[Q_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- sv/bdgp_ctrl.sv -----
module bdgp_ctrl
    import bdgp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_mode,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = '0;
        unique case (r_state)
            S_IDLE:  if (i_in_valid && i_mode) n_state = S_XS;
            S_XS:    n_state = i_stat.zero_size ? S_NORM : S_XW;
            S_XW:    if (i_stat.div_done) n_state = S_YS;
            S_YS:    n_state = S_YW;
            S_YW:    if (i_stat.div_done) n_state = S_FETCH;
            S_FETCH: begin
                n_step = r_step + 1'b1;
                if (r_step == 3'd4) begin
                    n_state = S_MAC;
                    n_step  = '0;
                end
            end
            S_MAC: begin
                n_step = r_step + 1'b1;
                if (t_mac_step'(r_step) == MAC_V) begin
                    n_state = S_NORM;
                    n_step  = '0;
                end
            end
            S_NORM:  n_state = i_stat.trivial ? S_EMIT : S_NS;
            S_NS:    n_state = S_NW;
            S_NW:    if (i_stat.div_done) n_state = S_EMIT;
            S_EMIT:  if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_go = i_in_valid && !i_mode;
                o_cmd.req_go  = i_in_valid && i_mode;
            end
            S_XS: begin
                o_cmd.v_zero   = i_stat.zero_size;
                o_cmd.div_go   = !i_stat.zero_size;
                o_cmd.div_kind = DK_X;
            end
            S_XW:  o_cmd.cx_lat = i_stat.div_done;
            S_YS: begin
                o_cmd.div_go   = 1'b1;
                o_cmd.div_kind = DK_Y;
            end
            S_YW:  o_cmd.cy_lat = i_stat.div_done;
            S_FETCH: begin
                o_cmd.rd_go   = (r_step != 3'd4);
                o_cmd.rd_idx  = r_step[1:0];
                o_cmd.cap_go  = (r_step != 3'd0);
                o_cmd.cap_idx = 2'(r_step - 1'b1);
            end
            S_MAC: begin
                o_cmd.mac_go   = 1'b1;
                o_cmd.mac_step = t_mac_step'(r_step);
            end
            S_NORM: o_cmd.norm_lat = 1'b1;
            S_NS: begin
                o_cmd.div_go   = 1'b1;
                o_cmd.div_kind = DK_N;
            end
            S_NW: ;
            S_EMIT: o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

// ----- sv/bdgp_dp.sv -----
module bdgp_dp
    import bdgp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_frame_start,
    input  logic [DEPTH_W-1:0] i_depth_value,
    input  logic               i_depth_invalid,
    input  logic [PIX_W-1:0]   i_pixel_x,
    input  logic [PIX_W-1:0]   i_pixel_y,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_gray,
    output logic               o_hit_invalid
);

    // configuration
    logic [SRC_W-1:0] r_src_w, r_src_h;
    logic [OUT_W-1:0] r_out_w, r_out_h;
    logic signed [DEPTH_W-1:0] r_pct_lo, r_pct_hi, r_min, r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= '0;
            r_src_h  <= '0;
            r_out_w  <= OUT_W'(1);
            r_out_h  <= OUT_W'(1);
            r_pct_lo <= '0;
            r_pct_hi <= '0;
            r_min    <= '0;
            r_max    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_w  <= i_cfg_data[SRC_W-1:0];
                CFG_SRC_HEIGHT: r_src_h  <= i_cfg_data[SRC_W-1:0];
                CFG_OUT_WIDTH:  r_out_w  <= i_cfg_data[OUT_W-1:0];
                CFG_OUT_HEIGHT: r_out_h  <= i_cfg_data[OUT_W-1:0];
                CFG_PCT_LOW:    r_pct_lo <= i_cfg_data;
                CFG_PCT_HIGH:   r_pct_hi <= i_cfg_data;
                CFG_MIN_VALUE:  r_min    <= i_cfg_data;
                CFG_MAX_VALUE:  r_max    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [SRC_W-1:0] sw, sh;
    logic [OUT_W-1:0] ow, oh;

    assign sw = (r_src_w > SRC_W'(MAX_SRC_WIDTH))  ? SRC_W'(MAX_SRC_WIDTH)  : r_src_w;
    assign sh = (r_src_h > SRC_W'(MAX_SRC_HEIGHT)) ? SRC_W'(MAX_SRC_HEIGHT) : r_src_h;
    assign ow = (r_out_w == '0) ? OUT_W'(1) :
                (r_out_w > OUT_W'(MAX_OUT_DIM)) ? OUT_W'(MAX_OUT_DIM) : r_out_w;
    assign oh = (r_out_h == '0) ? OUT_W'(1) :
                (r_out_h > OUT_W'(MAX_OUT_DIM)) ? OUT_W'(MAX_OUT_DIM) : r_out_h;

    // depth store: value plus invalid bit
    logic [DEPTH_W:0]    mem [0:STORE_DEPTH-1];
    logic [STORE_AW-1:0] r_wp;
    logic [STORE_AW-1:0] wr_addr;
    logic [STORE_AW-1:0] rd_addr;
    logic [DEPTH_W:0]    r_rd_data;

    assign wr_addr = i_frame_start ? '0 : r_wp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (i_cmd.load_go) begin
            r_wp <= wr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_go) begin
            mem[wr_addr] <= {i_depth_invalid, i_depth_value};
        end
        if (i_cmd.rd_go) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // request pixel
    logic [PIX_W-1:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_go) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
    end

    // shared divider
    logic [PIX_W-1:0]  p_sel;
    logic [SRC_W-1:0]  s_sel;
    logic [OUT_W-1:0]  o_sel;
    logic [CPRD_W-1:0] cprod;
    logic [DEN_W-1:0]  div_rem, div_den;
    logic [Q_W-1:0]    div_qin, div_quo;
    logic [CNT_W-1:0]  div_iters;
    logic              div_done;
    logic [D_W-1:0]    r_diff, r_d;
    logic [NUM_W-1:0]  nnum;

    assign p_sel = (i_cmd.div_kind == DK_Y) ? r_py : r_px;
    assign s_sel = (i_cmd.div_kind == DK_Y) ? sh : sw;
    assign o_sel = (i_cmd.div_kind == DK_Y) ? oh : ow;
    assign cprod = {p_sel, 1'b1} * s_sel;

    // 510*diff + d
    assign nnum = {r_diff, 9'b0} - {8'b0, r_diff, 1'b0} + {9'b0, r_d};

    always_comb begin
        case (i_cmd.div_kind)
            DK_N: begin
                div_rem   = nnum[NUM_W-1:N_BITS];
                div_qin   = {nnum[N_BITS-1:0], {(Q_W-N_BITS){1'b0}}};
                div_iters = CNT_W'(N_BITS);
                div_den   = {r_d, 1'b0};
            end
            default: begin
                div_rem   = '0;
                div_qin   = {cprod, {COORD_FRAC_BITS{1'b0}}, {(Q_W-CNUM_W){1'b0}}};
                div_iters = CNT_W'(CNUM_W);
                div_den   = DEN_W'({o_sel, 1'b0});
            end
        endcase
    end

    bdgp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_go),
        .i_rem   (div_rem),
        .i_quo   (div_qin),
        .i_iters (div_iters),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // coordinate: drop the half-pixel offset and clamp to the map
    logic [CNUM_W-1:0] cq, c_sub;
    logic [SRC_W-1:0]  src_m1;
    logic [CRD_W-1:0]  c_top, c_clamped;
    logic [CRD_W-1:0]  r_cx, r_cy;

    assign cq      = div_quo[CNUM_W-1:0];
    assign c_sub   = (cq < CNUM_W'(1 << (COORD_FRAC_BITS - 1))) ? '0 :
                     cq - CNUM_W'(1 << (COORD_FRAC_BITS - 1));
    assign src_m1  = (i_cmd.cy_lat ? sh : sw) - 1'b1;
    assign c_top   = {src_m1[IDX_W-1:0], {COORD_FRAC_BITS{1'b0}}};
    assign c_clamped = (c_sub > CNUM_W'(c_top)) ? c_top : c_sub[CRD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.cx_lat) r_cx <= c_clamped;
        if (i_cmd.cy_lat) r_cy <= c_clamped;
    end

    // neighbour addresses
    logic [IDX_W-1:0] x0, y0, x1, y1, xs, ys;
    logic [IDX_W:0]   x0p, y0p;
    logic [IDX_W+SRC_W-1:0] addr_full;

    assign x0  = r_cx[CRD_W-1:COORD_FRAC_BITS];
    assign y0  = r_cy[CRD_W-1:COORD_FRAC_BITS];
    assign x0p = {1'b0, x0} + 1'b1;
    assign y0p = {1'b0, y0} + 1'b1;
    assign x1  = (x0p < sw) ? x0p[IDX_W-1:0] : IDX_W'(sw - 1'b1);
    assign y1  = (y0p < sh) ? y0p[IDX_W-1:0] : IDX_W'(sh - 1'b1);
    assign xs  = i_cmd.rd_idx[0] ? x1 : x0;
    assign ys  = i_cmd.rd_idx[1] ? y1 : y0;
    assign addr_full = ys * sw + (IDX_W+SRC_W)'(xs);
    assign rd_addr   = addr_full[STORE_AW-1:0];

    // captured neighbours
    logic signed [DEPTH_W-1:0] r_e [0:3];
    logic r_inv;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_go) begin
            r_e[i_cmd.cap_idx] <= r_rd_data[DEPTH_W-1:0];
        end
    end

    // interpolation: one multiplier, stepped by the controller
    logic [WGT_W-1:0]           wx0, wx1, wy0, wy1, opb;
    logic signed [MA_W-1:0]     opa;
    logic signed [WGT_W:0]      opb_s;
    logic signed [MA_W+WGT_W:0] mul_res;
    logic signed [PROD_W-1:0]   r_prod, r_acc, mac_sum;
    logic signed [MA_W-1:0]     r_a, r_b;
    logic signed [V_W-1:0]      r_v;

    assign wx1 = {1'b0, r_cx[COORD_FRAC_BITS-1:0]};
    assign wy1 = {1'b0, r_cy[COORD_FRAC_BITS-1:0]};
    assign wx0 = WGT_W'(1 << COORD_FRAC_BITS) - wx1;
    assign wy0 = WGT_W'(1 << COORD_FRAC_BITS) - wy1;

    always_comb begin
        case (i_cmd.mac_step)
            MAC_E00: begin opa = MA_W'(r_e[0]); opb = wx0; end
            MAC_E10: begin opa = MA_W'(r_e[1]); opb = wx1; end
            MAC_E01: begin opa = MA_W'(r_e[2]); opb = wx0; end
            MAC_E11: begin opa = MA_W'(r_e[3]); opb = wx1; end
            MAC_AY:  begin opa = r_a;           opb = wy0; end
            MAC_BY:  begin opa = r_b;           opb = wy1; end
            default: begin opa = r_a;           opb = wy0; end
        endcase
    end

    assign opb_s   = $signed({1'b0, opb});
    assign mul_res = opa * opb_s;
    assign mac_sum = r_acc + r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_go) begin
            r_prod <= mul_res[PROD_W-1:0];
            case (i_cmd.mac_step)
                MAC_E10, MAC_E11, MAC_BY: r_acc <= r_prod;
                MAC_E01: r_a <= mac_sum[MA_W-1:0];
                MAC_B:   r_b <= mac_sum[MA_W-1:0];
                default: ;
            endcase
        end
        if (i_cmd.v_zero) begin
            r_v <= '0;
        end else if (i_cmd.mac_go && i_cmd.mac_step == MAC_V) begin
            r_v <= mac_sum[V_W+COORD_FRAC_BITS-1:COORD_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.v_zero) begin
            r_inv <= 1'b0;
        end else if (i_cmd.cap_go) begin
            r_inv <= r_rd_data[DEPTH_W] | ((i_cmd.cap_idx != 2'd0) & r_inv);
        end
    end

    // normalization bounds, scaled to the interpolated format
    logic signed [DEPTH_W-1:0] lo_raw, hi_raw;
    logic signed [V_W-1:0]     lo, hi, v_lo, hi_lo;
    logic                      empty, triv;
    logic [7:0]                triv_gray;
    logic                      r_trivial;
    logic [7:0]                r_triv_gray;

    assign lo_raw = (r_pct_hi > r_pct_lo) ? r_pct_lo : r_min;
    assign hi_raw = (r_pct_hi > r_pct_lo) ? r_pct_hi : r_max;
    assign lo     = $signed({lo_raw[DEPTH_W-1], lo_raw, {COORD_FRAC_BITS{1'b0}}});
    assign hi     = $signed({hi_raw[DEPTH_W-1], hi_raw, {COORD_FRAC_BITS{1'b0}}});
    assign empty  = (hi <= lo);
    assign v_lo   = r_v - lo;
    assign hi_lo  = hi - lo;

    always_comb begin
        triv      = 1'b1;
        triv_gray = 8'd0;
        if (r_inv) begin
            triv_gray = 8'd0;
        end else if (empty) begin
            triv_gray = (r_v > lo) ? 8'd255 : 8'd0;
        end else if (r_v <= lo) begin
            triv_gray = 8'd0;
        end else if (r_v >= hi) begin
            triv_gray = 8'd255;
        end else begin
            triv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_lat) begin
            r_trivial   <= triv;
            r_triv_gray <= triv_gray;
            r_diff      <= v_lo[D_W-1:0];
            r_d         <= hi_lo[D_W-1:0];
        end
    end

    // output register
    logic       r_out_valid;
    logic [7:0] r_gray;
    logic       r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_gray <= r_trivial ? r_triv_gray : div_quo[7:0];
            r_hit  <= r_inv;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_gray        = r_gray;
    assign o_hit_invalid = r_hit;

    assign o_stat.zero_size = (r_src_w == '0) || (r_src_h == '0);
    assign o_stat.div_done  = div_done;
    assign o_stat.trivial   = triv;
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ----- sv/bilinear_depth_to_gray_preview_unit.sv -----
// Depth-to-gray preview sampler. Load transfers (mode 0) write one Q16.16 depth
// sample plus invalid flag into a 512x512 map in raster order; frame_start
// restarts at entry zero and the write position wraps at the end of the map.
// Request transfers (mode 1) name an output pixel and return one gray value:
// the pixel centre is scaled into the map with 8 fraction bits, clamped,
// interpolated bilinearly over four neighbours and normalized between the
// percentile bounds (or min/max when the upper percentile is not above the
// lower) to 0..255, rounded half up. An invalid neighbour gives gray 0 with
// hit_invalid set; a zero source size samples 0. A request skips the
// normalization division when the value lands outside the bounds or a
// neighbour is invalid, and skips the coordinate divisions, map reads and
// multiply steps when the source size is zero; it then waits for a free
// output register, and the next transfer can be taken in the cycle after
// the result is loaded. The single shared restoring divider retires one
// quotient bit per cycle, 31 bits for each of the two coordinate scales and
// 8 for the normalization; the map's one read port fetches the four
// neighbours in turn and the one interpolation multiplier runs 8 steps,
// followed by the bound test and the output load. Input is stalled while
// a request is in flight. The result sits in an output register, so a new
// transfer is taken while it waits. Map entries never written read back as
// undefined. The user must write configuration through the plain write port
// only while the block is idle; the block itself does not enforce this.
module bilinear_depth_to_gray_preview_unit
    import bdgp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic               i_frame_start,
    input  logic [DEPTH_W-1:0] i_depth_value,
    input  logic               i_depth_invalid,
    input  logic [PIX_W-1:0]   i_pixel_x,
    input  logic [PIX_W-1:0]   i_pixel_y,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_gray,
    output logic               o_hit_invalid
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer: walks divider, map reads, multiply steps and output load
    bdgp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // datapath: registers, depth map, divider, multiplier, output register
    bdgp_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_frame_start   (i_frame_start),
        .i_depth_value   (i_depth_value),
        .i_depth_invalid (i_depth_invalid),
        .i_pixel_x       (i_pixel_x),
        .i_pixel_y       (i_pixel_y),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_gray          (o_gray),
        .o_hit_invalid   (o_hit_invalid)
    );

    // a request transfer must hold off the next input
    a_req_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_mode) |=> o_in_stall)
        else $error("request accepted but input not stalled");

    // never overwrite a result that is still waiting
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output overwritten while stalled");

    // an invalid neighbour forces gray to zero
    a_inv_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hit_invalid) |-> (o_gray == 8'd0))
        else $error("hit_invalid with nonzero gray");

    // output valid comes only from a load by the sequencer
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.out_load))
        else $error("output valid without load");

endmodule

// ----- tb/sv/tb.sv -----
module tb;
    import bdgp_pkg::*;

    localparam bit MODE_LOAD = 1'b0;
    localparam bit MODE_REQ  = 1'b1;
    localparam int CF        = 1 << COORD_FRAC_BITS;
    localparam int IDLE_LIMIT = 50000;

    typedef struct packed {
        logic [7:0] gray;
        logic       hit;
    } t_pixel;

    typedef int unsigned t_corners [4];

    // Tracks the depth map and registers, predicts gray pixels, checks results.
    class preview_scoreboard;
        logic signed [31:0] depth_val [STORE_DEPTH];
        bit                 depth_inv [STORE_DEPTH];
        bit                 depth_wr  [STORE_DEPTH];
        int unsigned        wr_pos;
        int unsigned        src_w, src_h, out_w, out_h;
        logic signed [31:0] pct_lo, pct_hi, min_v, max_v;
        t_pixel             expected_q [$];
        int                 fails;

        function new();
            wr_pos = 0;
            src_w  = 0;
            src_h  = 0;
            out_w  = 1;
            out_h  = 1;
            pct_lo = 0;
            pct_hi = 0;
            min_v  = 0;
            max_v  = 0;
            fails  = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                CFG_SRC_WIDTH:  src_w = d[SRC_W-1:0];
                CFG_SRC_HEIGHT: src_h = d[SRC_W-1:0];
                CFG_OUT_WIDTH:  out_w = d[OUT_W-1:0];
                CFG_OUT_HEIGHT: out_h = d[OUT_W-1:0];
                CFG_PCT_LOW:    pct_lo = d;
                CFG_PCT_HIGH:   pct_hi = d;
                CFG_MIN_VALUE:  min_v = d;
                CFG_MAX_VALUE:  max_v = d;
                default: ;
            endcase
        endfunction

        function int unsigned eff_src(int unsigned s, int unsigned lim);
            return (s > lim) ? lim : s;
        endfunction

        // pixel centre scaled into the map, clamped, COORD_FRAC_BITS fraction
        function longint unsigned scale_coord(longint unsigned p, longint unsigned src,
                                              longint unsigned od);
            longint unsigned num, c, top;
            if (od == 0) od = 1;
            if (od > MAX_OUT_DIM) od = MAX_OUT_DIM;
            top = (src - 1) << COORD_FRAC_BITS;
            num = ((2 * p + 1) * src) << COORD_FRAC_BITS;
            c = num / (2 * od);
            c = (c < CF / 2) ? 0 : c - CF / 2;
            if (c > top) c = top;
            return c;
        endfunction

        // returns 1 when the source size is zero; else the four corner entries
        function bit corners(int unsigned px, int unsigned py, output t_corners e,
                             output longint fx, output longint fy);
            int unsigned sw, sh, x0, y0, x1, y1;
            longint unsigned cx, cy;
            sw = eff_src(src_w, MAX_SRC_WIDTH);
            sh = eff_src(src_h, MAX_SRC_HEIGHT);
            e = '{default: 0};
            fx = 0;
            fy = 0;
            if (sw == 0 || sh == 0) return 1'b1;
            cx = scale_coord(px, sw, out_w);
            cy = scale_coord(py, sh, out_h);
            x0 = 32'(cx >> COORD_FRAC_BITS);
            y0 = 32'(cy >> COORD_FRAC_BITS);
            fx = cx & (CF - 1);
            fy = cy & (CF - 1);
            x1 = (x0 + 1 < sw) ? x0 + 1 : sw - 1;
            y1 = (y0 + 1 < sh) ? y0 + 1 : sh - 1;
            e[0] = (y0 * sw + x0) % STORE_DEPTH;
            e[1] = (y0 * sw + x1) % STORE_DEPTH;
            e[2] = (y1 * sw + x0) % STORE_DEPTH;
            e[3] = (y1 * sw + x1) % STORE_DEPTH;
            return 1'b0;
        endfunction

        function bit reads_unwritten(int unsigned px, int unsigned py);
            t_corners e;
            longint fx, fy;
            if (corners(px, py, e, fx, fy)) return 1'b0;
            foreach (e[k]) if (!depth_wr[e[k]]) return 1'b1;
            return 1'b0;
        endfunction

        function logic [7:0] to_gray(longint x, longint lo, longint hi);
            longint unsigned diff, d;
            if (hi <= lo) return (x > lo) ? 8'd255 : 8'd0;
            if (x <= lo) return 8'd0;
            if (x >= hi) return 8'd255;
            diff = x - lo;
            d = hi - lo;
            return 8'((510 * diff + d) / (2 * d));
        endfunction

        // accepted input transfer: update the map or queue the predicted pixel
        function void note(bit m, bit fs, logic [31:0] dv, bit inv,
                           logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            t_corners e;
            longint fx, fy, lo, hi, a, b, v;
            t_pixel p;
            if (m == MODE_LOAD) begin
                if (fs) wr_pos = 0;
                depth_val[wr_pos] = dv;
                depth_inv[wr_pos] = inv;
                depth_wr[wr_pos] = 1'b1;
                wr_pos = (wr_pos + 1 == STORE_DEPTH) ? 0 : wr_pos + 1;
                return;
            end
            if (pct_hi > pct_lo) begin
                lo = pct_lo;
                hi = pct_hi;
            end else begin
                lo = min_v;
                hi = max_v;
            end
            lo = lo * CF;
            hi = hi * CF;
            p.hit = 1'b0;
            if (corners(px, py, e, fx, fy)) begin
                p.gray = to_gray(0, lo, hi);
            end else if (depth_inv[e[0]] || depth_inv[e[1]] || depth_inv[e[2]] ||
                         depth_inv[e[3]]) begin
                p.gray = 0;
                p.hit = 1'b1;
            end else begin
                a = longint'(depth_val[e[0]]) * (CF - fx) + longint'(depth_val[e[1]]) * fx;
                b = longint'(depth_val[e[2]]) * (CF - fx) + longint'(depth_val[e[3]]) * fx;
                v = (a * (CF - fy) + b * fy) >>> COORD_FRAC_BITS;
                p.gray = to_gray(v, lo, hi);
            end
            expected_q = {expected_q, p};
        endfunction

        function void check(logic [7:0] gray, logic hit);
            t_pixel p;
            if (expected_q.size() == 0) begin
                fails++;
                if (fails <= 10) $display("unexpected pixel gray=%0d hit=%0b", gray, hit);
                return;
            end
            p = expected_q.pop_front();
            if (gray !== p.gray || hit !== p.hit) begin
                fails++;
                if (fails <= 10)
                    $display("pixel mismatch: expected gray=%0d hit=%0b, got gray=%0d hit=%0b",
                             p.gray, p.hit, gray, hit);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_mode = 1'b0;
    logic               i_frame_start = 1'b0;
    logic [DEPTH_W-1:0] i_depth_value = '0;
    logic               i_depth_invalid = 1'b0;
    logic [PIX_W-1:0]   i_pixel_x = '0;
    logic [PIX_W-1:0]   i_pixel_y = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_gray;
    logic               o_hit_invalid;

    preview_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int requests_sent = 0;

    bilinear_depth_to_gray_preview_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // Result side: check every transfer, stall at random for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check(o_gray, o_hit_invalid);
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task automatic write_all(int unsigned sw, int unsigned sh, int unsigned ow,
                             int unsigned oh, logic [31:0] pl, logic [31:0] ph,
                             logic [31:0] mn, logic [31:0] mx);
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_OUT_WIDTH, ow);
        write_reg(CFG_OUT_HEIGHT, oh);
        write_reg(CFG_PCT_LOW, pl);
        write_reg(CFG_PCT_HIGH, ph);
        write_reg(CFG_MIN_VALUE, mn);
        write_reg(CFG_MAX_VALUE, mx);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one input transfer; hold it until taken, then let the predictor see it.
    task automatic send(bit m, bit fs, logic [31:0] dv, bit inv,
                        logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_frame_start <= fs;
        i_depth_value <= dv;
        i_depth_invalid <= inv;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note(m, fs, dv, inv, px, py);
        if (m == MODE_REQ) requests_sent++;
    endtask

    task automatic request(int unsigned px, int unsigned py);
        send(MODE_REQ, 1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
             PIX_W'(px), PIX_W'(py));
    endtask

    // Pause input until every expected pixel is back, then let the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 88; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 88; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
        endcase
    endtask

    function automatic logic [31:0] rnd_depth(bit wide);
        if (wide) return $urandom;
        return $urandom_range(0, 1 << 21) - (1 << 20);
    endfunction

    // Well-formed phase: configure, load a whole map, then mostly requests
    // with an occasional stray load mixed in.
    task automatic run_phase(int phase, int unsigned sw, int unsigned sh, int unsigned ow,
                             int unsigned oh, int nreq, bit wide);
        int signed p0, p1, t;
        logic [31:0] pl, ph, mn, mx;
        int unsigned n, ow_e, oh_e, px, py, tries;
        set_idling(phase);
        p0 = rnd_depth(wide);
        p1 = rnd_depth(wide);
        if (p0 > p1) begin t = p0; p0 = p1; p1 = t; end
        case ($urandom_range(3))
            0: begin pl = p0; ph = p1; mn = rnd_depth(1); mx = rnd_depth(1); end
            1: begin pl = p1; ph = p1; mn = p0; mx = p1; end
            2: begin pl = p1; ph = p0; mn = p1; mx = p0; end
            default: begin pl = 32'h8000_0000; ph = 32'h7FFF_FFFF; mn = p0; mx = p1; end
        endcase
        write_all(sw, sh, ow, oh, pl, ph, mn, mx);
        n = sb.eff_src(sw, MAX_SRC_WIDTH) * sb.eff_src(sh, MAX_SRC_HEIGHT);
        for (int unsigned k = 0; k < n; k++)
            send(MODE_LOAD, k == 0, rnd_depth(wide), $urandom_range(99) < 3,
                 PIX_W'($urandom), PIX_W'($urandom));
        ow_e = (ow == 0) ? 1 : (ow > 4096 ? 4096 : ow);
        oh_e = (oh == 0) ? 1 : (oh > 4096 ? 4096 : oh);
        for (int r = 0; r < nreq; r++) begin
            if ($urandom_range(99) < 5) begin
                send(MODE_LOAD, $urandom_range(99) < 20, rnd_depth(wide),
                     $urandom_range(99) < 5, PIX_W'($urandom), PIX_W'($urandom));
                continue;
            end
            tries = 0;
            do begin
                px = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(ow_e - 1);
                py = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(oh_e - 1);
                tries++;
            end while (sb.reads_unwritten(px, py) && tries < 50);
            if (!sb.reads_unwritten(px, py)) request(px, py);
        end
        drain();
    endtask

    initial begin
        int phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: zero source size, empty bound range.
        request(0, 0);
        request(4095, 4095);
        drain();

        // Directed 2x2 map: depth extremes, bounds, pixel extremes.
        write_all(2, 2, 2, 2, 32'hFFFF_0000, 32'h0001_0000, 0, 0);
        send(MODE_LOAD, 1, 32'h7FFF_FFFF, 0, 0, 0);
        send(MODE_LOAD, 0, 32'h8000_0000, 0, 0, 0);
        send(MODE_LOAD, 0, 32'h0000_0000, 0, 0, 0);
        send(MODE_LOAD, 0, 32'h0000_8000, 0, 0, 0);
        request(0, 0);
        request(1, 1);
        request(4095, 4095);
        request(0, 4095);
        request(1, 0);
        // invalid neighbour on the last entry
        send(MODE_LOAD, 1, 32'h0000_1000, 0, 0, 0);
        send(MODE_LOAD, 0, 32'h0000_2000, 0, 0, 0);
        send(MODE_LOAD, 0, 32'h0000_3000, 0, 0, 0);
        send(MODE_LOAD, 0, 32'h0000_4000, 1, 0, 0);
        request(0, 0);
        request(1, 1);
        drain();
        // empty bound range on both bound pairs, and the widest fallback range
        write_all(2, 2, 2, 2, 32'h0000_5000, 32'h0000_5000, 32'h0000_2800, 32'h0000_2800);
        request(0, 0);
        request(1, 1);
        drain();
        write_all(2, 2, 2, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        request(0, 0);
        request(1, 1);
        drain();

        // Corner configurations: zero sizes, 1x1 map, zero and oversized output,
        // oversized source width saturating to the widest map.
        run_phase(1, 0, 5, 4, 4, 10, 1);
        run_phase(2, 3, 0, 4, 4, 10, 0);
        run_phase(3, 1, 1, 1, 1, 10, 1);
        run_phase(0, 4, 4, 8, 8, 20, 0);
        run_phase(1, 8, 5, 0, 8191, 20, 0);
        run_phase(3, 1023, 1, 700, 3, 20, 1);

        // Random well-formed phases.
        phase = 0;
        while (requests_sent < 280) begin
            run_phase(phase, $urandom_range(1, 8), $urandom_range(1, 8),
                      ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64),
                      ($urandom_range(9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64),
                      30, $urandom_range(1));
            phase++;
        end

        if (sb.fails == 0 && sb.expected_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
